// ----- sv/cjk_line_break_marker_assert.svh -----
// ----------------------------------------------------------------------------
// CJK line break marker assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CJK_LINE_BREAK_MARKER_ASSERT_SVH
`define CJK_LINE_BREAK_MARKER_ASSERT_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define CJK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define CJK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CJK_ASSERT(lbl, prop, msg)
`define CJK_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/cjkbrk_pkg.sv -----
// ----------------------------------------------------------------------------
// CJK line break marker package
// Code page modes, special bytes, lead byte test and punctuation tables.
// ----------------------------------------------------------------------------
package cjkbrk_pkg;

  // code page mode register values
  localparam logic [1:0] MODE_PASS = 2'd0;  // pass through
  localparam logic [1:0] MODE_JP   = 2'd1;  // 932
  localparam logic [1:0] MODE_SC   = 2'd2;  // 936
  localparam logic [1:0] MODE_TC   = 2'd3;  // 950

  localparam logic [7:0] MARK_BYTE  = 8'h5C;  // backslash
  localparam logic [7:0] FMT_LETTER = 8'h66;  // 'f'
  localparam logic [7:0] FMT_END    = 8'h3B;  // ';'

  // one request worth of output bytes, slot 0 goes out first
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [2:0]      marks;
    logic [1:0]      cnt;
    logic            last;
  } result_t;

  // first byte of a double-byte character
  function automatic logic is_lead(input logic [1:0] mode, input logic [7:0] b);
    logic r;
    if (mode == MODE_JP) r = (b inside {[8'h81:8'h9F], [8'hE0:8'hFC]});
    else                 r = (b inside {[8'h81:8'hFE]});
    return r;
  endfunction

  // opening punctuation: no break after it
  function automatic logic is_opening(input logic [1:0] mode, input logic [15:0] code);
    logic r;
    r = 1'b0;
    case (mode)
      MODE_JP: begin
        case (code)
          16'h0024, 16'h00A2, 16'h816D, 16'h8177, 16'h0028, 16'h8165, 16'h816F,
          16'h8179, 16'h005B, 16'h8167, 16'h8171, 16'h818F, 16'h005C, 16'h8169,
          16'h8173, 16'h8190, 16'h007B, 16'h816B, 16'h8175, 16'h8192: r = 1'b1;
          default: r = 1'b0;
        endcase
      end
      MODE_SC: begin
        case (code)
          16'h0028, 16'hA1B6, 16'hA3B0, 16'hA3B7, 16'h005B, 16'hA1B8, 16'hA3B1,
          16'hA3B8, 16'h007B, 16'hA1BA, 16'hA3B2, 16'hA3B9, 16'hA1AE, 16'hA1BC,
          16'hA3B3, 16'hA3DB, 16'hA1B0, 16'hA1BE, 16'hA3B4, 16'hA3FB, 16'hA1B2,
          16'hA3A8, 16'hA3B5, 16'hA1B4, 16'hA3AE, 16'hA3B6: r = 1'b1;
          default: r = 1'b0;
        endcase
      end
      MODE_TC: begin
        case (code)
          16'h0028, 16'hA165, 16'hA173, 16'hA1A3, 16'h005B, 16'hA167, 16'hA175,
          16'hA1A5, 16'h007B, 16'hA169, 16'hA177, 16'hA1A7, 16'hA15D, 16'hA16B,
          16'hA179, 16'hA1A9, 16'hA15F, 16'hA16D, 16'hA17B, 16'hA1AB, 16'hA161,
          16'hA16F, 16'hA17D, 16'hA163, 16'hA171, 16'hA1A1: r = 1'b1;
          default: r = 1'b0;
        endcase
      end
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // closing punctuation: no break before it
  function automatic logic is_closing(input logic [1:0] mode, input logic [15:0] code);
    logic r;
    r = 1'b0;
    case (mode)
      MODE_JP: begin
        case (code)
          16'h0021, 16'h00B0, 16'h8168, 16'h82A7, 16'h0025, 16'h00DE, 16'h816A,
          16'h82C1, 16'h0029, 16'h00DF, 16'h816C, 16'h82E1, 16'h002C, 16'h8141,
          16'h816E, 16'h82E3, 16'h002E, 16'h8142, 16'h8170, 16'h82E5, 16'h003F,
          16'h8143, 16'h8172, 16'h82EC, 16'h005D, 16'h8144, 16'h8174, 16'h8340,
          16'h007D, 16'h8145, 16'h8176, 16'h8342, 16'h00A1, 16'h8146, 16'h8178,
          16'h8344, 16'h00A3, 16'h8147, 16'h817A, 16'h8346, 16'h00A4, 16'h8148,
          16'h818B, 16'h8348, 16'h00A5, 16'h8149, 16'h818C, 16'h8362, 16'h00A7,
          16'h814A, 16'h818D, 16'h8383, 16'h00A8, 16'h814B, 16'h818E, 16'h8385,
          16'h00A9, 16'h8152, 16'h8191, 16'h8387, 16'h00AA, 16'h8153, 16'h8193,
          16'h838E, 16'h00AB, 16'h8154, 16'h81F1, 16'h8395, 16'h00AC, 16'h8155,
          16'h829F, 16'h8396, 16'h00AD, 16'h8158, 16'h82A1, 16'h00AE, 16'h815B,
          16'h82A3, 16'h00AF, 16'h8166, 16'h82A5: r = 1'b1;
          default: r = 1'b0;
        endcase
      end
      MODE_SC: begin
        case (code)
          16'h0021, 16'hA1A4, 16'hA1B1, 16'hA3A7, 16'h0029, 16'hA1A5, 16'hA1B3,
          16'hA3A9, 16'h002C, 16'hA1A6, 16'hA1B5, 16'hA3AC, 16'h002E, 16'hA1A7,
          16'hA1B7, 16'hA3AE, 16'h003A, 16'hA1A8, 16'hA1B9, 16'hA3BA, 16'h003B,
          16'hA1A9, 16'hA1BB, 16'hA3BB, 16'h003F, 16'hA1AA, 16'hA1BD, 16'hA3BF,
          16'h005D, 16'hA1AB, 16'hA1BF, 16'hA3DD, 16'h007D, 16'hA1AC, 16'hA1C3,
          16'hA3E0, 16'hA1A2, 16'hA1AD, 16'hA3A1, 16'hA3FC, 16'hA1A3, 16'hA1AF,
          16'hA3A2, 16'hA3FD: r = 1'b1;
          default: r = 1'b0;
        endcase
      end
      MODE_TC: begin
        case (code)
          16'h0021, 16'hA147, 16'hA156, 16'hA16E, 16'h0029, 16'hA148, 16'hA157,
          16'hA170, 16'h002C, 16'hA149, 16'hA158, 16'hA172, 16'h002E, 16'hA14A,
          16'hA159, 16'hA174, 16'h003A, 16'hA14B, 16'hA15A, 16'hA176, 16'h003B,
          16'hA14C, 16'hA15B, 16'hA178, 16'h003F, 16'hA14D, 16'hA15C, 16'hA17A,
          16'h005D, 16'hA14E, 16'hA15E, 16'hA17C, 16'h007D, 16'hA14F, 16'hA160,
          16'hA17E, 16'hA141, 16'hA150, 16'hA162, 16'hA1A2, 16'hA142, 16'hA151,
          16'hA164, 16'hA1A4, 16'hA143, 16'hA152, 16'hA166, 16'hA1A6, 16'hA144,
          16'hA153, 16'hA168, 16'hA1A8, 16'hA145, 16'hA154, 16'hA16A, 16'hA1AA,
          16'hA146, 16'hA155, 16'hA16C, 16'hA1AC: r = 1'b1;
          default: r = 1'b0;
        endcase
      end
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/cjkbrk_step.sv -----
// ----------------------------------------------------------------------------
// CJK line break marker step logic
// Text state registers and the per-byte decision: mark, held byte, byte.
// ----------------------------------------------------------------------------
`include "cjk_line_break_marker_assert.svh"

module cjkbrk_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            mode,
  input  logic                  take,       // byte consumed this cycle
  input  logic [7:0]            in_byte,
  input  logic                  in_fin,
  output cjkbrk_pkg::result_t   res
);
  import cjkbrk_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_BSLASH,
    PH_FMT,
    PH_FMT_TRAIL
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] held, held_next;
  logic       pab, pab_next;     // previous character allows a break
  logic       em_mark, em_a, em_b;
  logic       lead, opening, closing;
  logic [15:0] code;

  // classification of the character ending with this byte
  always_comb begin
    lead    = is_lead(mode, in_byte);
    code    = (phase == PH_LEAD) ? {held, in_byte} : {8'h00, in_byte};
    opening = is_opening(mode, code);
    closing = is_closing(mode, code) && !opening;
  end

  // next state and which bytes go out
  always_comb begin
    phase_next = phase;
    held_next  = held;
    pab_next   = pab;
    em_mark    = 1'b0;
    em_a       = 1'b0;
    em_b       = 1'b0;
    if (mode == MODE_PASS) begin
      em_a       = (phase == PH_LEAD);
      em_b       = 1'b1;
      phase_next = PH_IDLE;
      held_next  = 8'h00;
      pab_next   = 1'b0;
    end else begin
      case (phase)
        PH_LEAD: begin
          em_mark    = pab && !closing;
          em_a       = 1'b1;
          em_b       = 1'b1;
          pab_next   = !opening;
          held_next  = 8'h00;
          phase_next = PH_IDLE;
        end
        PH_FMT_TRAIL: begin
          em_b       = 1'b1;
          phase_next = PH_FMT;
        end
        PH_FMT: begin
          em_b = 1'b1;
          if (lead)                    phase_next = PH_FMT_TRAIL;
          else if (in_byte == FMT_END) phase_next = PH_IDLE;
        end
        default: begin
          if (phase == PH_BSLASH && in_byte == FMT_LETTER) begin
            em_b       = 1'b1;
            phase_next = PH_FMT;
          end else if (lead) begin
            held_next  = in_byte;
            phase_next = PH_LEAD;
          end else begin
            em_mark    = pab && in_byte[7] && !closing;
            em_b       = 1'b1;
            pab_next   = (mode == MODE_JP) && (in_byte inside {[8'hA1:8'hDF]}) && !opening;
            phase_next = (in_byte == MARK_BYTE) ? PH_BSLASH : PH_IDLE;
          end
        end
      endcase
    end
    // end of text: flush a lone lead byte, then clear
    if (in_fin) begin
      if (phase_next == PH_LEAD) em_b = 1'b1;
      phase_next = PH_IDLE;
      held_next  = 8'h00;
      pab_next   = 1'b0;
    end
  end

  // pack mark, held byte and byte into consecutive slots
  always_comb begin
    res = '0;
    res.cnt = {1'b0, em_mark} + {1'b0, em_a} + {1'b0, em_b};
    res.last = in_fin;
    if (em_mark) begin
      res.bytes[0] = MARK_BYTE;
      res.marks[0] = 1'b1;
    end
    if (em_a) res.bytes[{1'b0, em_mark}] = held;
    if (em_b) res.bytes[{1'b0, em_mark} + {1'b0, em_a}] = in_byte;
  end

  // text state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= 8'h00;
      pab   <= 1'b0;
    end else if (take) begin
      phase <= phase_next;
      held  <= held_next;
      pab   <= pab_next;
    end
  end

  `CJK_ASSERT(a_fin_clears, (take && in_fin) |=> (phase == PH_IDLE && !pab), "state not cleared after final byte")
  `CJK_ASSERT(a_mark_first, (take && res.cnt != 2'd0) |-> (res.marks[2:1] == 2'b00), "break mark outside first slot")

endmodule

// ----- sv/cjkbrk_obuf.sv -----
// ----------------------------------------------------------------------------
// CJK line break marker output buffer
// Holds up to three result bytes of one request and drains them in order.
// ----------------------------------------------------------------------------
`include "cjk_line_break_marker_assert.svh"

module cjkbrk_obuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  cjkbrk_pkg::result_t  res,
  output logic                 free,    // can load this cycle
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // out_byte
  output logic                 m_tuser,   // is_break_mark
  output logic                 m_tlast
);
  import cjkbrk_pkg::*;

  logic [2:0][7:0] bytes;
  logic [2:0]      marks;
  logic [1:0]      cnt;
  logic            last;
  logic            pop;

  assign m_tvalid = (cnt != 2'd0);
  assign pop      = m_tvalid && m_tready;
  assign free     = (cnt == 2'd0) || (cnt == 2'd1 && pop);
  assign m_tdata  = bytes[0];
  assign m_tuser  = marks[0];
  assign m_tlast  = last && (cnt == 2'd1);

  // fill count, control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= res.cnt;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // slot data, shifted down on each pop
  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= res.bytes;
      marks <= res.marks;
      last  <= res.last;
    end else if (pop) begin
      bytes <= {8'h00, bytes[2:1]};
      marks <= {1'b0, marks[2:1]};
    end
  end

  `CJK_ASSERT(a_load_free, load |-> free, "load into occupied buffer")
  `CJK_ASSERT_ALWAYS(a_rst_empty, $past(rst) |-> (cnt == 2'd0), "buffer not empty after reset")

endmodule

// ----- sv/cjk_line_break_marker.sv -----
// A request is registered on accept; its result bytes are loaded into the output
// register once that register is free, and are valid at the output from that load.
// Input bytes are taken at one per cycle while the output register can load; a byte
// that yields n results (up to 3) holds the output register until the single output port drains them.
// Reset: rst is synchronous, active high; clears the text state, empties the
// buffers and sets the code page mode to pass through.
// ----------------------------------------------------------------------------
// CJK line break marker
// Copies a multibyte text stream and inserts backslash break marks.
// ----------------------------------------------------------------------------
module cjk_line_break_marker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // text_byte
  input  logic       s_tlast,    // final_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // out_byte
  output logic       m_tuser,    // is_break_mark
  output logic       m_tlast,    // last_out
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data    // code_page_mode
);
  import cjkbrk_pkg::*;

  logic [1:0] code_page_mode;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_fin;
  logic       take;
  logic       free;
  result_t    res;

  assign cfg_ready = 1'b1;
  assign take      = in_valid && free;
  assign s_tready  = !in_valid || take;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_page_mode <= MODE_PASS;
    end else if (cfg_valid && cfg_ready) begin
      code_page_mode <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_fin  <= s_tlast;
    end
  end

  cjkbrk_step u_step (
    .clk     (clk),
    .rst     (rst),
    .mode    (code_page_mode),
    .take    (take),
    .in_byte (in_byte),
    .in_fin  (in_fin),
    .res     (res)
  );

  cjkbrk_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .res      (res),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CJK line break marker testbench
// Streams multibyte text through the marker in all four code page modes and
// checks every output byte, mark flag and end flag against a local model of
// the kinsoku rules. A short directed table comes first, then random runs of
// well-formed characters, punctuation and format codes mixed with noise.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import cjkbrk_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TEXT_ITEMS  = 300;
  localparam int JP_OPEN_N   = 20;
  localparam int SC_OPEN_N   = 26;
  localparam int TC_OPEN_N   = 26;

  typedef enum logic [2:0] {PH_IDLE, PH_LEAD, PH_BSLASH, PH_FMT, PH_FMT_TRAIL} text_phase_t;
  typedef enum logic [1:0] {PUNCT_PLAIN, PUNCT_OPEN, PUNCT_CLOSE} punct_t;

  typedef struct packed {
    logic [7:0] data;
    logic       mark;
    logic       last;
  } text_out_t;

  // one directed row: a mode write or a text byte, optionally with typed results
  typedef struct packed {
    logic            is_cfg;
    logic [7:0]      val;
    logic            fin;
    logic            typed;
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic [2:0]      marks;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       m_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data = MODE_PASS;

  // opening entries first, closing after; a code in both counts as opening
  logic [15:0] jp_punct [0:100] = '{
    16'h24, 16'hA2, 16'h816D, 16'h8177, 16'h28, 16'h8165, 16'h816F, 16'h8179,
    16'h5B, 16'h8167, 16'h8171, 16'h818F, 16'h5C, 16'h8169, 16'h8173, 16'h8190,
    16'h7B, 16'h816B, 16'h8175, 16'h8192,
    16'h21, 16'hB0, 16'h8168, 16'h82A7, 16'h25, 16'hDE, 16'h816A, 16'h82C1,
    16'h29, 16'hDF, 16'h816C, 16'h82E1, 16'h2C, 16'h8141, 16'h816E, 16'h82E3,
    16'h2E, 16'h8142, 16'h8170, 16'h82E5, 16'h3F, 16'h8143, 16'h8172, 16'h82EC,
    16'h5D, 16'h8144, 16'h8174, 16'h8340, 16'h7D, 16'h8145, 16'h8176, 16'h8342,
    16'hA1, 16'h8146, 16'h8178, 16'h8344, 16'hA3, 16'h8147, 16'h817A, 16'h8346,
    16'hA4, 16'h8148, 16'h818B, 16'h8348, 16'hA5, 16'h8149, 16'h818C, 16'h8362,
    16'hA7, 16'h814A, 16'h818D, 16'h8383, 16'hA8, 16'h814B, 16'h818E, 16'h8385,
    16'hA9, 16'h8152, 16'h8191, 16'h8387, 16'hAA, 16'h8153, 16'h8193, 16'h838E,
    16'hAB, 16'h8154, 16'h81F1, 16'h8395, 16'hAC, 16'h8155, 16'h829F, 16'h8396,
    16'hAD, 16'h8158, 16'h82A1, 16'hAE, 16'h815B, 16'h82A3, 16'hAF, 16'h8166, 16'h82A5};

  logic [15:0] sc_punct [0:69] = '{
    16'h28, 16'hA1B6, 16'hA3B0, 16'hA3B7, 16'h5B, 16'hA1B8, 16'hA3B1, 16'hA3B8,
    16'h7B, 16'hA1BA, 16'hA3B2, 16'hA3B9, 16'hA1AE, 16'hA1BC, 16'hA3B3, 16'hA3DB,
    16'hA1B0, 16'hA1BE, 16'hA3B4, 16'hA3FB, 16'hA1B2, 16'hA3A8, 16'hA3B5,
    16'hA1B4, 16'hA3AE, 16'hA3B6,
    16'h21, 16'hA1A4, 16'hA1B1, 16'hA3A7, 16'h29, 16'hA1A5, 16'hA1B3, 16'hA3A9,
    16'h2C, 16'hA1A6, 16'hA1B5, 16'hA3AC, 16'h2E, 16'hA1A7, 16'hA1B7, 16'hA3AE,
    16'h3A, 16'hA1A8, 16'hA1B9, 16'hA3BA, 16'h3B, 16'hA1A9, 16'hA1BB, 16'hA3BB,
    16'h3F, 16'hA1AA, 16'hA1BD, 16'hA3BF, 16'h5D, 16'hA1AB, 16'hA1BF, 16'hA3DD,
    16'h7D, 16'hA1AC, 16'hA1C3, 16'hA3E0, 16'hA1A2, 16'hA1AD, 16'hA3A1, 16'hA3FC,
    16'hA1A3, 16'hA1AF, 16'hA3A2, 16'hA3FD};

  logic [15:0] tc_punct [0:85] = '{
    16'h28, 16'hA165, 16'hA173, 16'hA1A3, 16'h5B, 16'hA167, 16'hA175, 16'hA1A5,
    16'h7B, 16'hA169, 16'hA177, 16'hA1A7, 16'hA15D, 16'hA16B, 16'hA179, 16'hA1A9,
    16'hA15F, 16'hA16D, 16'hA17B, 16'hA1AB, 16'hA161, 16'hA16F, 16'hA17D,
    16'hA163, 16'hA171, 16'hA1A1,
    16'h21, 16'hA147, 16'hA156, 16'hA16E, 16'h29, 16'hA148, 16'hA157, 16'hA170,
    16'h2C, 16'hA149, 16'hA158, 16'hA172, 16'h2E, 16'hA14A, 16'hA159, 16'hA174,
    16'h3A, 16'hA14B, 16'hA15A, 16'hA176, 16'h3B, 16'hA14C, 16'hA15B, 16'hA178,
    16'h3F, 16'hA14D, 16'hA15C, 16'hA17A, 16'h5D, 16'hA14E, 16'hA15E, 16'hA17C,
    16'h7D, 16'hA14F, 16'hA160, 16'hA17E, 16'hA141, 16'hA150, 16'hA162, 16'hA1A2,
    16'hA142, 16'hA151, 16'hA164, 16'hA1A4, 16'hA143, 16'hA152, 16'hA166, 16'hA1A6,
    16'hA144, 16'hA153, 16'hA168, 16'hA1A8, 16'hA145, 16'hA154, 16'hA16A, 16'hA1AA,
    16'hA146, 16'hA155, 16'hA16C, 16'hA1AC};

  // model state
  logic [1:0]  code_mode = MODE_PASS;
  text_phase_t text_phase = PH_IDLE;
  logic [7:0]  held_lead = 8'h00;
  logic        brk_ok = 1'b0;

  text_out_t   step_q [$];
  text_out_t   text_expect [$];
  text_out_t   next_want;
  dir_row_t    dir_rows [$];
  logic [7:0]  run_bytes [$];
  int          mismatch_cnt = 0;
  int          sent_items = 0;
  int          cycle_cnt;
  bit          calm_tx = 1'b0;
  bit          calm_rx = 1'b0;

  cjk_line_break_marker u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---- local model of the kinsoku rules ----

  function automatic logic lead_byte(input logic [1:0] mode, input logic [7:0] b);
    if (mode == MODE_JP) return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
    return b >= 8'h81 && b <= 8'hFE;
  endfunction

  // scan downward so the lowest match (opening before closing) wins
  function automatic punct_t punct_class(input logic [1:0] mode, input logic [15:0] code);
    punct_t cls;
    cls = PUNCT_PLAIN;
    case (mode)
      MODE_JP: begin
        for (int k = 100; k >= 0; k--)
          if (jp_punct[k] == code) cls = (k < JP_OPEN_N) ? PUNCT_OPEN : PUNCT_CLOSE;
      end
      MODE_SC: begin
        for (int k = 69; k >= 0; k--)
          if (sc_punct[k] == code) cls = (k < SC_OPEN_N) ? PUNCT_OPEN : PUNCT_CLOSE;
      end
      MODE_TC: begin
        for (int k = 85; k >= 0; k--)
          if (tc_punct[k] == code) cls = (k < TC_OPEN_N) ? PUNCT_OPEN : PUNCT_CLOSE;
      end
      default: cls = PUNCT_PLAIN;
    endcase
    return cls;
  endfunction

  task automatic emit_byte(input logic [7:0] b, input logic mark);
    text_out_t o;
    o.data = b;
    o.mark = mark;
    o.last = 1'b0;
    step_q.push_back(o);
  endtask

  task automatic clear_text();
    text_phase = PH_IDLE;
    held_lead = 8'h00;
    brk_ok = 1'b0;
  endtask

  // work out the output bytes of one accepted text byte into step_q
  task automatic predict_text(input logic [7:0] b, input logic fin, input bit keep);
    punct_t    cls;
    text_out_t o;
    step_q.delete();
    if (code_mode == MODE_PASS) begin
      if (text_phase == PH_LEAD) emit_byte(held_lead, 1'b0);
      emit_byte(b, 1'b0);
      clear_text();
    end else if (text_phase == PH_LEAD) begin
      cls = punct_class(code_mode, {held_lead, b});
      if (brk_ok && cls != PUNCT_CLOSE) emit_byte(MARK_BYTE, 1'b1);
      emit_byte(held_lead, 1'b0);
      emit_byte(b, 1'b0);
      brk_ok = (cls != PUNCT_OPEN);
      held_lead = 8'h00;
      text_phase = PH_IDLE;
    end else if (text_phase == PH_FMT_TRAIL) begin
      emit_byte(b, 1'b0);
      text_phase = PH_FMT;
    end else if (text_phase == PH_FMT) begin
      emit_byte(b, 1'b0);
      if (lead_byte(code_mode, b)) text_phase = PH_FMT_TRAIL;
      else if (b == FMT_END) text_phase = PH_IDLE;
    end else if (text_phase == PH_BSLASH && b == FMT_LETTER) begin
      emit_byte(b, 1'b0);
      text_phase = PH_FMT;
    end else if (lead_byte(code_mode, b)) begin
      held_lead = b;
      text_phase = PH_LEAD;
    end else begin
      cls = punct_class(code_mode, {8'h00, b});
      if (brk_ok && b > 8'h7F && cls != PUNCT_CLOSE) emit_byte(MARK_BYTE, 1'b1);
      emit_byte(b, 1'b0);
      // half-width kana allows a break after it in Japanese mode
      brk_ok = (code_mode == MODE_JP) && (b >= 8'hA1) && (b <= 8'hDF) && (cls != PUNCT_OPEN);
      text_phase = (b == MARK_BYTE) ? PH_BSLASH : PH_IDLE;
    end

    // end of text: flush a held lead byte and flag the last output
    if (fin) begin
      if (text_phase == PH_LEAD) emit_byte(held_lead, 1'b0);
      clear_text();
      if (step_q.size() > 0) begin
        o = step_q.pop_back();
        o.last = 1'b1;
        step_q.push_back(o);
      end
    end
    if (keep) foreach (step_q[i]) text_expect.push_back(step_q[i]);
  endtask

  // ---- stimulus ----

  // one text request; keep = 0 when the caller queues typed results itself
  task automatic send_byte(input logic [7:0] b, input logic fin, input bit keep);
    int gap;
    gap = calm_tx ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    predict_text(b, fin, keep);
    sent_items++;
  endtask

  // mode writes only once the output side has drained
  task automatic write_mode(input logic [1:0] mode);
    s_tvalid <= 1'b0;
    while (text_expect.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    code_mode = mode;
  endtask

  function automatic logic [7:0] pick_lead(input logic [1:0] mode);
    if (mode == MODE_JP)
      return $urandom_range(0, 1) ? 8'($urandom_range(8'h81, 8'h9F))
                                  : 8'($urandom_range(8'hE0, 8'hFC));
    return 8'($urandom_range(8'h81, 8'hFE));
  endfunction

  function automatic logic [15:0] pick_punct(input logic [1:0] mode);
    case (mode)
      MODE_SC: return sc_punct[$urandom_range(0, 69)];
      MODE_TC: return tc_punct[$urandom_range(0, 85)];
      default: return jp_punct[$urandom_range(0, 100)];
    endcase
  endfunction

  // one random run of characters, mostly ending in a final byte
  task automatic send_text_run();
    int          n_tok;
    int          n_in;
    logic [15:0] pc;
    bit          close_run;
    run_bytes.delete();
    n_tok = $urandom_range(1, 8);
    close_run = ($urandom_range(0, 7) != 0);
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(0, 9))
        0, 1: run_bytes.push_back(8'($urandom_range(0, 127)));
        2, 3: begin
          run_bytes.push_back(pick_lead(code_mode));
          run_bytes.push_back(8'($urandom_range(0, 255)));
        end
        4, 5: begin
          pc = pick_punct(code_mode);
          if (pc[15:8] != 8'h00) run_bytes.push_back(pc[15:8]);
          run_bytes.push_back(pc[7:0]);
        end
        6: run_bytes.push_back(8'($urandom_range(8'hA1, 8'hDF)));
        7: begin
          // format code, sometimes left open
          run_bytes.push_back(MARK_BYTE);
          run_bytes.push_back(FMT_LETTER);
          n_in = $urandom_range(0, 3);
          for (int i = 0; i < n_in; i++) begin
            if ($urandom_range(0, 2) == 0) begin
              run_bytes.push_back(pick_lead(code_mode));
              run_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
              run_bytes.push_back(8'($urandom_range(0, 127)));
            end
          end
          if ($urandom_range(0, 3) != 0) run_bytes.push_back(FMT_END);
        end
        8: begin
          run_bytes.push_back(MARK_BYTE);
          run_bytes.push_back(8'($urandom_range(0, 255)));
        end
        default: run_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    foreach (run_bytes[i])
      send_byte(run_bytes[i], close_run && (i == run_bytes.size() - 1), 1'b1);
  endtask

  task automatic drow(input logic [7:0] val, input logic fin);
    dir_row_t r;
    r = '0;
    r.val = val;
    r.fin = fin;
    dir_rows.push_back(r);
  endtask

  task automatic trow(input logic [7:0] val, input logic fin, input logic [1:0] cnt,
                      input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                      input logic [2:0] marks);
    dir_row_t r;
    r = '0;
    r.val = val;
    r.fin = fin;
    r.typed = 1'b1;
    r.cnt = cnt;
    r.bytes[0] = b0;
    r.bytes[1] = b1;
    r.bytes[2] = b2;
    r.marks = marks;
    dir_rows.push_back(r);
  endtask

  task automatic crow(input logic [1:0] mode);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.val = {6'd0, mode};
    dir_rows.push_back(r);
  endtask

  // ---- output checking ----

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (text_expect.size() == 0) begin
        report_mismatch("output byte with nothing pending", int'(m_tdata), 0);
      end else begin
        next_want = text_expect.pop_front();
        if (m_tdata !== next_want.data)
          report_mismatch("out byte", int'(m_tdata), int'(next_want.data));
        if (m_tuser !== next_want.mark)
          report_mismatch("break mark", int'(m_tuser), int'(next_want.mark));
        if (m_tlast !== next_want.last)
          report_mismatch("last flag", int'(m_tlast), int'(next_want.last));
      end
    end
  end

  // output side: random stalls per result, with calm stretches
  initial begin : out_side
    int stall;
    int served;
    served = 0;
    while (rst) @(posedge clk);
    forever begin
      if (served % 40 == 0) calm_rx = ($urandom_range(0, 3) == 0);
      stall = calm_rx ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      served++;
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  // ---- main sequence ----
  initial begin : stim
    dir_row_t  r;
    text_out_t t;

    // pass-through extremes right after reset
    trow(8'h00, 1'b0, 2'd1, 8'h00, 8'h00, 8'h00, 3'b000);
    trow(8'hFF, 1'b1, 2'd1, 8'hFF, 8'h00, 8'h00, 3'b000);
    // Japanese: plain char, closing, kana, opening, format code, lone lead at end
    crow(MODE_JP);
    drow(8'h88, 1'b0);
    trow(8'h9F, 1'b0, 2'd2, 8'h88, 8'h9F, 8'h00, 3'b000);
    drow(8'h81, 1'b0);
    drow(8'h41, 1'b0);
    drow(8'hB1, 1'b0);
    drow(8'h81, 1'b0);
    drow(8'h6D, 1'b0);
    drow(MARK_BYTE, 1'b0);
    drow(FMT_LETTER, 1'b0);
    drow(8'h88, 1'b0);
    drow(FMT_END, 1'b0);
    drow(FMT_END, 1'b0);
    trow(8'hE0, 1'b1, 2'd1, 8'hE0, 8'h00, 8'h00, 3'b000);
    // simplified: zero trail, code in both tables, unterminated format code
    crow(MODE_SC);
    drow(8'hFE, 1'b0);
    drow(8'h00, 1'b0);
    drow(8'hA3, 1'b0);
    drow(8'hAE, 1'b0);
    drow(MARK_BYTE, 1'b0);
    drow(FMT_LETTER, 1'b0);
    drow(8'h41, 1'b1);
    // traditional: closing char, then a high single byte that gets a mark
    crow(MODE_TC);
    drow(8'hA1, 1'b0);
    drow(8'h41, 1'b0);
    trow(8'h80, 1'b1, 2'd2, MARK_BYTE, 8'h80, 8'h00, 3'b001);
    // mode change with a lead byte held
    crow(MODE_JP);
    drow(8'h81, 1'b0);
    crow(MODE_PASS);
    trow(8'h41, 1'b1, 2'd2, 8'h81, 8'h41, 8'h00, 3'b000);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.is_cfg) begin
        write_mode(r.val[1:0]);
      end else begin
        send_byte(r.val, r.fin, !r.typed);
        if (r.typed) begin
          for (int k = 0; k < r.cnt; k++) begin
            t.data = r.bytes[k];
            t.mark = r.marks[k];
            t.last = r.fin && (k == r.cnt - 1);
            text_expect.push_back(t);
          end
        end
      end
    end

    // random runs, mode changed now and then
    while (sent_items < TEXT_ITEMS) begin
      if ($urandom_range(0, 3) == 0) write_mode(2'($urandom_range(0, 3)));
      calm_tx = ($urandom_range(0, 4) == 0);
      send_text_run();
    end

    s_tvalid <= 1'b0;
    while (text_expect.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/cjkbrk_pkg.sv
sv/cjkbrk_step.sv
sv/cjkbrk_obuf.sv
sv/cjk_line_break_marker.sv
dv/tb_top.sv
